// ----- rtl/greedy_word_wrap_layout_defines.svh -----
// Assertion macros shared by the layout checker.
// No dependencies; pulled in by `include where assertions are written.
`ifndef GREEDY_WORD_WRAP_LAYOUT_DEFINES_SVH
`define GREEDY_WORD_WRAP_LAYOUT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define GWWL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("layout check failed");

// Next-cycle implication, disabled while reset is low.
`define GWWL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("layout check failed");

`endif

// ----- rtl/gwwl_pkg.sv -----
// Shared types, constants and helper functions for the word-wrap layout block.
// No dependencies; imported by every RTL module of the block.
package gwwl_pkg;

    localparam int C_W    = 13;   // coordinate width
    localparam int W_W    = 8;    // glyph advance width
    localparam int L_W    = 12;   // line counter width
    localparam int ARG_W  = 16;   // headroom for coordinate sums
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [C_W-1:0] COORD_MAX    = 13'd8191;
    localparam logic [L_W-1:0] LINES_MAX    = 12'd4095;
    localparam logic [C_W-1:0] START_X_RST  = 13'd50;
    localparam logic [C_W-1:0] WRAP_RST     = 13'd8191;
    localparam logic [W_W-1:0] LINE_H_RST   = 8'd20;

    typedef enum logic [1:0] {
        REG_START_X,
        REG_KEEP_X,
        REG_WRAP_LIMIT,
        REG_LINE_HEIGHT
    } t_reg_idx;

    typedef struct packed {
        logic [C_W-1:0] start_x;
        logic           keep_original_x;
        logic [C_W-1:0] wrap_limit;
        logic [W_W-1:0] line_height;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // capture input item
        logic calc1;    // first decision stage
        logic calc2;    // second decision stage, commit layout state
        logic rd;       // fetch next result source
        logic put;      // load output register
        logic store;    // write held glyph into word buffer
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic a_more;   // buffered glyphs still to emit
        logic b_more;   // current glyph still to emit
        logic out_free; // output register can take a result
    } t_status;

    function automatic logic [C_W-1:0] f_sat13(input logic [ARG_W-1:0] v);
        return (v > ARG_W'(COORD_MAX)) ? COORD_MAX : v[C_W-1:0];
    endfunction

    function automatic logic f_wraps(input logic [ARG_W-1:0] v,
                                     input logic [C_W-1:0]   lim);
        return (lim != COORD_MAX) && (v > ARG_W'(lim));
    endfunction

endpackage

// ----- rtl/gwwl_regs.sv -----
// APB-style configuration registers of the word-wrap layout block.
// Depends on gwwl_pkg for the register map and the t_cfg type.
module gwwl_regs
    import gwwl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_sel;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_x         <= START_X_RST;
            r_cfg.keep_original_x <= 1'b0;
            r_cfg.wrap_limit      <= WRAP_RST;
            r_cfg.line_height     <= LINE_H_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_START_X:     r_cfg.start_x         <= pwdata[C_W-1:0];
                REG_KEEP_X:      r_cfg.keep_original_x <= pwdata[0];
                REG_WRAP_LIMIT:  r_cfg.wrap_limit      <= pwdata[C_W-1:0];
                REG_LINE_HEIGHT: r_cfg.line_height     <= pwdata[W_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_START_X:     prdata = DATA_W'(r_cfg.start_x);
            REG_KEEP_X:      prdata = DATA_W'(r_cfg.keep_original_x);
            REG_WRAP_LIMIT:  prdata = DATA_W'(r_cfg.wrap_limit);
            REG_LINE_HEIGHT: prdata = DATA_W'(r_cfg.line_height);
            default:         prdata = '0;
        endcase
    end

endmodule

// ----- rtl/gwwl_dp.sv -----
// Datapath: layout state, word buffer memory, placement arithmetic, output register.
// Depends on gwwl_pkg; sequenced by gwwl_ctrl through t_cmd / t_status.
module gwwl_dp
    import gwwl_pkg::*;
#(
    parameter int WORD_DEPTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cmd           i_cmd,
    output t_status        o_status,
    input  t_cfg           i_cfg,
    input  logic [W_W-1:0] i_glyph_width,
    input  logic           i_is_space,
    input  logic [C_W-1:0] i_orig_x,
    input  logic [C_W-1:0] i_top_in,
    input  logic [C_W-1:0] i_bottom_in,
    input  logic           i_end_of_text,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [C_W-1:0] o_left_x,
    output logic [C_W-1:0] o_right_x,
    output logic [C_W-1:0] o_top_out,
    output logic [C_W-1:0] o_bottom_out,
    output logic           o_run_last,
    output logic           o_text_done,
    output logic [L_W-1:0] o_line_count
);

    localparam int LW = $clog2(WORD_DEPTH + 1);      // holds 0..WORD_DEPTH
    localparam int IW = $clog2(WORD_DEPTH);          // buffer index
    localparam int SW = $clog2(WORD_DEPTH * 255 + 1);

    typedef struct packed {
        logic [W_W-1:0] w;
        logic [C_W-1:0] top;
        logic [C_W-1:0] bot;
    } t_glyph;

    t_glyph mem [WORD_DEPTH];

    // captured input item
    t_glyph         r_glyph;
    logic           r_in_sp;
    logic [C_W-1:0] r_in_ox;
    logic           r_in_eot;

    // layout state
    logic [C_W-1:0] r_cursor, r_offset, r_base, r_wsx;
    logic [L_W-1:0] r_lines;
    logic           r_first, r_whsb;
    logic [LW-1:0]  r_len;
    logic [SW-1:0]  r_sum;

    // first decision stage
    logic [C_W-1:0]   r_lb, r_ca, r_wsx0, r_alt, r_off1, r_off2;
    logic [ARG_W-1:0] r_nx1, r_lbw;
    logic [L_W-1:0]   r_ln1, r_ln2;
    logic             r_full, r_whsba, r_wrap1;

    // emission
    logic           r_aen, r_ben, r_bdone, r_selb, r_wen;
    logic [LW-1:0]  r_acnt, r_idx;
    logic [IW-1:0]  r_widx;
    logic [C_W-1:0] r_xacc, r_oa, r_xb, r_ob;
    logic [L_W-1:0] r_lc;
    t_glyph         r_rd;

    // output register
    logic           r_ovalid, r_olast, r_odone;
    logic [C_W-1:0] r_oleft, r_oright, r_otop, r_obot;
    logic [L_W-1:0] r_olc;

    // ---------------- stage 1 ----------------
    logic [C_W-1:0]   c1_lb, c1_c0, c1_wsx0, c1_ca;
    logic [SW-1:0]    c1_suma;
    logic             c1_full;
    logic [ARG_W-1:0] c1_nx1;

    always_comb begin
        c1_lb   = r_first ? (i_cfg.keep_original_x ? r_in_ox : i_cfg.start_x) : r_base;
        c1_c0   = r_first ? c1_lb : r_cursor;
        c1_wsx0 = r_first ? c1_lb : r_wsx;
        c1_full = !r_in_sp && (r_len == LW'(WORD_DEPTH));
        c1_ca   = c1_full ? c1_lb : c1_c0;    // full buffer flushes and breaks first
        c1_suma = c1_full ? '0 : r_sum;
        c1_nx1  = ARG_W'(c1_ca) + ARG_W'(r_glyph.w);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_glyph.w   <= i_glyph_width;
            r_glyph.top <= i_top_in;
            r_glyph.bot <= i_bottom_in;
            r_in_sp     <= i_is_space;
            r_in_ox     <= i_orig_x;
            r_in_eot    <= i_end_of_text;
        end
        if (i_cmd.calc1) begin
            r_lb    <= c1_lb;
            r_ca    <= c1_ca;
            r_wsx0  <= c1_wsx0;
            r_full  <= c1_full;
            r_whsba <= c1_full ? 1'b0 : r_whsb;
            r_nx1   <= c1_nx1;
            r_wrap1 <= f_wraps(c1_nx1, i_cfg.wrap_limit);
            r_alt   <= f_sat13(ARG_W'(c1_lb) + ARG_W'(c1_suma));
            r_lbw   <= ARG_W'(c1_lb) + ARG_W'(r_glyph.w);
            r_off1  <= f_sat13(ARG_W'(r_offset) + ARG_W'(i_cfg.line_height));
            r_off2  <= f_sat13(ARG_W'(r_offset) + ARG_W'({i_cfg.line_height, 1'b0}));
            r_ln1   <= (r_lines == LINES_MAX) ? r_lines : r_lines + L_W'(1);
            r_ln2   <= (r_lines >= LINES_MAX - L_W'(1)) ? LINES_MAX : r_lines + L_W'(2);
        end
    end

    // ---------------- stage 2 ----------------
    logic             c2_w1, c2_mid, c2_brk;
    logic [1:0]       c2_nl;
    logic [C_W-1:0]   c2_cb, c2_off;
    logic [ARG_W-1:0] c2_nx2;
    logic [L_W-1:0]   c2_lines;
    logic [C_W-1:0]   n_cursor, n_wsx, n_xa, n_oa, n_xb, n_ob;
    logic             n_whsb, n_aen, n_ben, n_wen;
    logic [LW-1:0]    n_len;
    logic [SW-1:0]    n_sum;
    logic [IW-1:0]    n_widx;

    always_comb begin
        // word that had a space before it moves whole to a new line
        c2_w1  = !r_in_sp && r_wrap1 && r_whsba;
        c2_cb  = c2_w1 ? r_alt : r_ca;
        c2_nx2 = ARG_W'(c2_cb) + ARG_W'(r_glyph.w);
        // word still overflows: break before this glyph
        c2_mid = !r_in_sp && !r_full && (r_len != '0) && f_wraps(c2_nx2, i_cfg.wrap_limit);
        c2_brk = r_full || c2_mid;
        c2_nl  = r_in_sp ? {1'b0, r_wrap1}
                         : ({1'b0, r_full} + {1'b0, c2_w1} + {1'b0, c2_mid});
        case (c2_nl)
            2'd0: begin
                c2_off   = r_offset;
                c2_lines = r_lines;
            end
            2'd1: begin
                c2_off   = r_off1;
                c2_lines = r_ln1;
            end
            default: begin
                c2_off   = r_off2;
                c2_lines = r_ln2;
            end
        endcase

        if (r_in_sp) begin
            n_cursor = r_wrap1 ? r_lb : f_sat13(r_nx1);
            n_wsx    = n_cursor;
            n_whsb   = !r_wrap1;
            n_len    = '0;
            n_sum    = '0;
            n_widx   = '0;
            n_wen    = 1'b0;
            n_aen    = 1'b1;
            n_ben    = 1'b1;
            n_xa     = r_wsx0;
            n_oa     = r_offset;
            n_xb     = r_ca;
            n_ob     = r_offset;
        end else begin
            n_cursor = c2_mid ? f_sat13(r_lbw) : f_sat13(c2_nx2);
            n_wsx    = (r_full || c2_w1 || c2_mid) ? r_lb : r_wsx0;
            n_whsb   = r_whsba && !c2_w1 && !c2_mid;
            n_widx   = c2_brk ? '0 : r_len[IW-1:0];
            n_len    = c2_brk ? LW'(1) : r_len + LW'(1);
            n_sum    = (c2_brk ? '0 : r_sum) + SW'(r_glyph.w);
            n_wen    = 1'b1;
            n_aen    = c2_brk || r_in_eot;
            n_ben    = r_in_eot;
            n_xa     = c2_w1 ? r_lb : r_wsx0;
            n_oa     = c2_w1 ? r_off1 : r_offset;
            n_xb     = c2_mid ? r_lb : c2_cb;
            n_ob     = c2_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_offset <= '0;
            r_lines  <= L_W'(1);
            r_base   <= '0;
            r_first  <= 1'b1;
            r_whsb   <= 1'b0;
            r_len    <= '0;
            r_sum    <= '0;
            r_wsx    <= '0;
        end else if (i_cmd.calc2) begin
            if (r_in_eot) begin
                // text ends: layout returns to its idle values
                r_cursor <= '0;
                r_offset <= '0;
                r_lines  <= L_W'(1);
                r_base   <= '0;
                r_first  <= 1'b1;
                r_whsb   <= 1'b0;
                r_len    <= '0;
                r_sum    <= '0;
                r_wsx    <= '0;
            end else begin
                r_cursor <= n_cursor;
                r_offset <= c2_off;
                r_lines  <= c2_lines;
                r_base   <= r_lb;
                r_first  <= 1'b0;
                r_whsb   <= n_whsb;
                r_len    <= n_len;
                r_sum    <= n_sum;
                r_wsx    <= n_wsx;
            end
        end
    end

    // ---------------- emission ----------------
    logic           a_more, b_more, out_free, p_last;
    logic [C_W-1:0] p_x, p_right, p_off;
    t_glyph         p_g;

    assign a_more   = r_aen && (r_idx < r_acnt);
    assign b_more   = r_ben && !r_bdone;
    assign out_free = !r_ovalid || i_out_ready;

    assign o_status.a_more   = a_more;
    assign o_status.b_more   = b_more;
    assign o_status.out_free = out_free;

    always_comb begin
        p_g     = r_selb ? r_glyph : r_rd;
        p_x     = r_selb ? r_xb : r_xacc;
        p_off   = r_selb ? r_ob : r_oa;
        p_right = f_sat13(ARG_W'(p_x) + ARG_W'(p_g.w));
        p_last  = r_selb || (!r_ben && ((r_idx + LW'(1)) == r_acnt));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aen   <= 1'b0;
            r_ben   <= 1'b0;
            r_bdone <= 1'b0;
            r_wen   <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.calc2) begin
                r_aen   <= n_aen;
                r_ben   <= n_ben;
                r_bdone <= 1'b0;
                r_wen   <= n_wen;
                r_idx   <= '0;
            end else if (i_cmd.put) begin
                if (r_selb) begin
                    r_bdone <= 1'b1;
                end else begin
                    r_idx <= r_idx + LW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc2) begin
            r_acnt <= r_len;
            r_xacc <= n_xa;
            r_oa   <= n_oa;
            r_xb   <= n_xb;
            r_ob   <= n_ob;
            r_lc   <= c2_lines;
            r_widx <= n_widx;
        end else if (i_cmd.put && !r_selb) begin
            r_xacc <= p_right;
        end
        if (i_cmd.rd) begin
            r_selb <= !a_more;
        end
    end

    // word buffer: registered read, single write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd && a_more) begin
            r_rd <= mem[r_idx[IW-1:0]];
        end
        if (i_cmd.store && r_wen) begin
            mem[r_widx] <= r_glyph;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.put) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_oleft  <= p_x;
            r_oright <= p_right;
            r_otop   <= f_sat13(ARG_W'(p_g.top) + ARG_W'(p_off));
            r_obot   <= f_sat13(ARG_W'(p_g.bot) + ARG_W'(p_off));
            r_olast  <= p_last;
            r_odone  <= p_last && r_in_eot;
            r_olc    <= r_lc;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_left_x     = r_oleft;
    assign o_right_x    = r_oright;
    assign o_top_out    = r_otop;
    assign o_bottom_out = r_obot;
    assign o_run_last   = r_olast;
    assign o_text_done  = r_odone;
    assign o_line_count = r_olc;

endmodule

// ----- rtl/gwwl_ctrl.sv -----
// Controller FSM: sequences decision stages, result emission and buffer write.
// Depends on gwwl_pkg for the t_cmd / t_status bundles.
module gwwl_ctrl
    import gwwl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC1,
        S_CALC2,
        S_RD,
        S_PUT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CALC1;
                end
            end
            S_CALC1: begin
                o_cmd.calc1 = 1'b1;
                n_state     = S_CALC2;
            end
            S_CALC2: begin
                o_cmd.calc2 = 1'b1;
                n_state     = S_RD;
            end
            S_RD: begin
                if (i_status.a_more || i_status.b_more) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_PUT;
                end else begin
                    o_cmd.store = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_PUT: begin
                if (i_status.out_free) begin
                    o_cmd.put = 1'b1;
                    n_state   = S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/greedy_word_wrap_layout.sv -----
// Top level of the greedy word-wrap layout block: APB registers, controller, datapath.
// Depends on gwwl_pkg, gwwl_regs, gwwl_ctrl and gwwl_dp.
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one glyph item per handshake:
//   width, space flag, original x, top/bottom y and end-of-text mark.
//   Output channel (o_out_valid / i_out_ready) delivers placed glyph items.
//   Non-space glyphs are held in a WORD_DEPTH-entry word buffer until a space,
//   a wrap break, a full buffer or the end of text releases them; one input
//   item yields from zero up to WORD_DEPTH+1 result items.
//   Sequence: each accepted item passes the two-stage placement decision; each
//   result then takes one registered word-buffer read and one output load.
//   The block takes no new item until the current one is fully processed.
//   Receiver stall: the output register holds its item and emission pauses;
//   input stays blocked until the item's last result is in the output register.
//   Reset (i_rst_n low, synchronous): registers return to their defaults
//   (start_x 50, wrap_limit 8191, line_height 20), layout state clears; the
//   word buffer needs no clearing since only written entries are ever read.
//   Configuration writes are intended only while no item is in flight.
module greedy_word_wrap_layout
    import gwwl_pkg::*;
#(
    parameter int WORD_DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // glyph input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [W_W-1:0]    i_glyph_width,
    input  logic              i_is_space,
    input  logic [C_W-1:0]    i_orig_x,
    input  logic [C_W-1:0]    i_top_in,
    input  logic [C_W-1:0]    i_bottom_in,
    input  logic              i_end_of_text,
    // placed glyph output channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [C_W-1:0]    o_left_x,
    output logic [C_W-1:0]    o_right_x,
    output logic [C_W-1:0]    o_top_out,
    output logic [C_W-1:0]    o_bottom_out,
    output logic              o_run_last,
    output logic              o_text_done,
    output logic [L_W-1:0]    o_line_count
);

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    // register file; pready is tied high inside
    gwwl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer: accept, decide (two stages), emit loop, buffer write
    gwwl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // layout state, word buffer and output register
    gwwl_dp #(
        .WORD_DEPTH (WORD_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg         (cfg),
        .i_glyph_width (i_glyph_width),
        .i_is_space    (i_is_space),
        .i_orig_x      (i_orig_x),
        .i_top_in      (i_top_in),
        .i_bottom_in   (i_bottom_in),
        .i_end_of_text (i_end_of_text),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_left_x      (o_left_x),
        .o_right_x     (o_right_x),
        .o_top_out     (o_top_out),
        .o_bottom_out  (o_bottom_out),
        .o_run_last    (o_run_last),
        .o_text_done   (o_text_done),
        .o_line_count  (o_line_count)
    );

endmodule

// ----- rtl/gwwl_checker.sv -----
// Port-level checker for the word-wrap layout block, bound to the top level.
// Depends on greedy_word_wrap_layout_defines.svh for the assertion macros.
`include "greedy_word_wrap_layout_defines.svh"

module gwwl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [12:0] o_left_x,
    input logic [12:0] o_right_x,
    input logic        o_run_last,
    input logic        o_text_done,
    input logic [11:0] o_line_count
);

    logic        box_ok;
    logic        stalled;
    logic [14:0] out_word;

    assign box_ok   = (o_right_x >= o_left_x) && (o_line_count != 12'd0);
    assign stalled  = o_out_valid && !i_out_ready;
    assign out_word = {o_out_valid, o_left_x, o_run_last};

    // an accepted glyph occupies the block for at least the decision stages
    `GWWL_ASSERT_NEXT(a_accept_blocks, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // end of text is always marked on the closing item of its run
    `GWWL_ASSERT_SAME(a_done_is_last, i_clk, i_rst_n, o_out_valid && o_text_done, o_run_last)

    // placed box never inverted, at least one line in use
    `GWWL_ASSERT_SAME(a_box_sane, i_clk, i_rst_n, o_out_valid, box_ok)

    // stalled result holds
    `GWWL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stalled, $stable(out_word))

endmodule

bind greedy_word_wrap_layout gwwl_checker u_gwwl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_left_x     (o_left_x),
    .o_right_x    (o_right_x),
    .o_run_last   (o_run_last),
    .o_text_done  (o_text_done),
    .o_line_count (o_line_count)
);
